// ===== rtl/core/frm_pkg.sv =====
// Shared constants, configuration codes and divider control type for the frame rate meter.
`default_nettype none

package frm_pkg;

    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int TS_W       = 64;
    localparam int FRAMES_W   = 32;
    localparam int MIN_W      = 32;
    localparam int WEIGHT_W   = 17;
    localparam int PERIOD_W   = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEP_W = 7;

    localparam logic [63:0]         NS_PER_SEC    = 64'd1000000000;
    localparam logic [63:0]         RATE_CEIL_FPS = 64'd2000;
    localparam logic [WEIGHT_W-1:0] Q16_ONE       = 17'd65536;
    localparam logic [15:0]         Q16_HALF      = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd4;

    localparam logic [MIN_W-1:0]    MIN_INTERVAL_RST  = 32'd500000;
    localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST    = 17'd5243;
    localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST  = 17'd45875;
    localparam logic [PERIOD_W-1:0] REPORT_PERIOD_RST = 8'd8;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } div_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/frm_div.sv =====
// Radix-2 restoring divider that produces one quotient bit per cycle.
`default_nettype none

module frm_div #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  frm_pkg::div_ctl_t  ctl,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [NUM_W-1:0]   quo,
    output logic [DEN_W-1:0]   rem
);
    import frm_pkg::*;

    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      rem_next;
    logic [NUM_W-1:0]      quo_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DEN_W:0]        trial;
    logic                  take;

    // The numerator arrives left aligned, so after the requested number of
    // steps the quotient sits in the low bits of the shift register.
    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        take     = (trial >= {1'b0, den_reg});
        rem_next = take ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[NUM_W-2:0], take};
                cnt_reg <= cnt_reg - DIV_STEP_W'(1);
                if (cnt_reg == DIV_STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/frame_rate_meter.sv =====
// Top level of the frame rate meter: event intake, sample ring, averages and reporting.
//
//  Channel   Direction  Handshake            Contents
//  s_        in         s_tvalid / s_tready  timestamp_ns
//  m_        out        m_tvalid / m_tready  blended_fps, frames
//  cfg_      in         cfg_wr_en            register index and write data
//
// One event is handled at a time. An event that yields a sample goes through the rate
// division, the ring and average update and the report test, with every division run on
// the one-bit-per-cycle divider. A reporting event adds the window mean division and the
// blend. A disabled, first or rejected event yields no sample and returns to idle.
// The ring needs no clearing pass after reset, since the fill count marks unwritten
// entries. The block keeps working while a result waits and stalls only when a new
// result is ready and the output register is still occupied.
`default_nettype none

module frame_rate_meter #(
    parameter int WINDOW_DEPTH = frm_pkg::WINDOW_DEPTH_DEF,
    parameter int FRAC_BITS    = frm_pkg::FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // timestamp_ns [63:0]
    input  logic [frm_pkg::TS_W-1:0]                s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // blended_fps [FRAC_BITS+10:0], frames above it, zero padding at the top
    output logic [((FRAC_BITS+43+7)/8)*8-1:0]       m_tdata,
    input  logic                                    cfg_wr_en,
    input  logic [frm_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [frm_pkg::CFG_DATA_W-1:0]          cfg_wdata
);
    import frm_pkg::*;

    localparam int RATE_W  = FRAC_BITS + 11;
    localparam int NUM_W   = FRAC_BITS + 30;
    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = RATE_W + $clog2(WINDOW_DEPTH);
    localparam int DIV_W   = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int PROD_W  = RATE_W + WEIGHT_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int TDATA_W = ((RATE_W + FRAMES_W + 7) / 8) * 8;

    localparam logic [DIV_W-1:0] RATE_NUM_AL =
        DIV_W'(NS_PER_SEC << FRAC_BITS) << (DIV_W - NUM_W);
    localparam logic [DIV_W-1:0] RATE_CEIL = DIV_W'(RATE_CEIL_FPS << FRAC_BITS);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_RDIV  = 4'd1;
    localparam logic [ST_W-1:0] ST_UPD   = 4'd2;
    localparam logic [ST_W-1:0] ST_EMA1  = 4'd3;
    localparam logic [ST_W-1:0] ST_EMA2  = 4'd4;
    localparam logic [ST_W-1:0] ST_EMA3  = 4'd5;
    localparam logic [ST_W-1:0] ST_MOD   = 4'd6;
    localparam logic [ST_W-1:0] ST_MODW  = 4'd7;
    localparam logic [ST_W-1:0] ST_MEANW = 4'd8;
    localparam logic [ST_W-1:0] ST_BL1   = 4'd9;
    localparam logic [ST_W-1:0] ST_BL2   = 4'd10;
    localparam logic [ST_W-1:0] ST_BL3   = 4'd11;
    localparam logic [ST_W-1:0] ST_OUT   = 4'd12;

    logic [ST_W-1:0]     state_reg;

    logic                enable_reg;
    logic [MIN_W-1:0]    min_int_reg;
    logic [WEIGHT_W-1:0] ema_w_reg;
    logic [WEIGHT_W-1:0] blend_w_reg;
    logic [PERIOD_W-1:0] period_reg;

    logic [TS_W-1:0]     last_time_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [RATE_W-1:0]   smooth_reg;
    logic                seeded_reg;
    logic [FRAMES_W-1:0] frame_total_reg;

    logic [RATE_W-1:0]   ring_mem [WINDOW_DEPTH];
    logic [RATE_W-1:0]   ring_q_reg;

    logic [RATE_W-1:0]   rate_reg;
    logic [RATE_W-1:0]   mean_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic                m_valid_reg;
    logic [RATE_W-1:0]   blend_out_reg;
    logic [FRAMES_W-1:0] frames_out_reg;
    logic [RATE_W-1:0]   mix_res;

    logic                in_accept;
    logic [TS_W-1:0]     dt;
    logic                dt_ok;
    logic                rate_ok;
    logic [WEIGHT_W-1:0] ema_w_sat;
    logic [WEIGHT_W-1:0] ema_w_inv;
    logic [WEIGHT_W-1:0] blend_w_sat;
    logic [WEIGHT_W-1:0] blend_w_inv;
    logic [PERIOD_W-1:0] period_eff;
    logic [RATE_W-1:0]   mul_a;
    logic [WEIGHT_W-1:0] mul_b;
    logic [ACC_W-1:0]    mix_sum;
    logic [RATE_W-1:0]   old_rate;
    logic                ring_full;
    logic                out_free;
    logic                out_load;

    div_ctl_t            div_ctl;
    logic [DIV_W-1:0]    div_num;
    logic [TS_W-1:0]     div_den;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic [TS_W-1:0]     div_rem;

    frm_div #(
        .NUM_W (DIV_W),
        .DEN_W (TS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_OUT) && out_free;
    assign ring_full = (fill_reg == FILL_W'(WINDOW_DEPTH));

    always_comb begin
        dt          = s_tdata - last_time_reg;
        dt_ok       = (last_time_reg != '0) && (dt > TS_W'(min_int_reg));
        rate_ok     = (div_quo != '0) && (div_quo < RATE_CEIL);
        ema_w_sat   = (ema_w_reg > Q16_ONE) ? Q16_ONE : ema_w_reg;
        ema_w_inv   = Q16_ONE - ema_w_sat;
        blend_w_sat = (blend_w_reg > Q16_ONE) ? Q16_ONE : blend_w_reg;
        blend_w_inv = Q16_ONE - blend_w_sat;
        period_eff  = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        old_rate    = ring_full ? ring_q_reg : '0;
        mix_sum     = acc_reg + ACC_W'(prod_reg);
        mix_res     = mix_sum[16 +: RATE_W];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_EMA1: begin
                mul_a = rate_reg;
                mul_b = ema_w_sat;
            end
            ST_EMA2: begin
                mul_a = smooth_reg;
                mul_b = ema_w_inv;
            end
            ST_BL1: begin
                mul_a = smooth_reg;
                mul_b = blend_w_sat;
            end
            ST_BL2: begin
                mul_a = mean_reg;
                mul_b = blend_w_inv;
            end
            default: ;
        endcase
    end

    always_comb begin
        div_ctl = '0;
        div_num = '0;
        div_den = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && enable_reg && dt_ok) begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = DIV_STEP_W'(NUM_W);
                    div_num       = RATE_NUM_AL;
                    div_den       = dt;
                end
            end
            ST_MOD: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = DIV_STEP_W'(FRAMES_W);
                div_num       = DIV_W'(frame_total_reg) << (DIV_W - FRAMES_W);
                div_den       = TS_W'(period_eff);
            end
            ST_MODW: begin
                if (div_done && div_rem == '0) begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = DIV_STEP_W'(SUM_W);
                    div_num       = DIV_W'(sum_reg) << (DIV_W - SUM_W);
                    div_den       = TS_W'(fill_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ring_q_reg <= ring_mem[idx_reg];
        end
        if (state_reg == ST_UPD) begin
            ring_mem[idx_reg] <= rate_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a * mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            min_int_reg <= MIN_INTERVAL_RST;
            ema_w_reg   <= EMA_WEIGHT_RST;
            blend_w_reg <= BLEND_WEIGHT_RST;
            period_reg  <= REPORT_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE:        enable_reg  <= cfg_wdata[0];
                CFG_MIN_INTERVAL:  min_int_reg <= cfg_wdata[MIN_W-1:0];
                CFG_EMA_WEIGHT:    ema_w_reg   <= cfg_wdata[WEIGHT_W-1:0];
                CFG_BLEND_WEIGHT:  blend_w_reg <= cfg_wdata[WEIGHT_W-1:0];
                CFG_REPORT_PERIOD: period_reg  <= cfg_wdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            last_time_reg   <= '0;
            idx_reg         <= '0;
            fill_reg        <= '0;
            sum_reg         <= '0;
            smooth_reg      <= '0;
            seeded_reg      <= 1'b0;
            frame_total_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept && enable_reg) begin
                        last_time_reg <= s_tdata;
                        if (dt_ok) begin
                            state_reg <= ST_RDIV;
                        end
                    end
                end
                ST_RDIV: begin
                    if (div_done) begin
                        rate_reg  <= div_quo[RATE_W-1:0];
                        state_reg <= rate_ok ? ST_UPD : ST_IDLE;
                    end
                end
                ST_UPD: begin
                    sum_reg <= sum_reg - SUM_W'(old_rate) + SUM_W'(rate_reg);
                    idx_reg <= (idx_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                      : idx_reg + IDX_W'(1);
                    if (!ring_full) begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                    frame_total_reg <= frame_total_reg + FRAMES_W'(1);
                    if (!seeded_reg) begin
                        smooth_reg <= rate_reg;
                        seeded_reg <= 1'b1;
                        state_reg  <= ST_MOD;
                    end else begin
                        state_reg <= ST_EMA1;
                    end
                end
                ST_EMA1: begin
                    state_reg <= ST_EMA2;
                end
                ST_EMA2: begin
                    acc_reg   <= ACC_W'(prod_reg) + ACC_W'(Q16_HALF);
                    state_reg <= ST_EMA3;
                end
                ST_EMA3: begin
                    smooth_reg <= mix_res;
                    state_reg  <= ST_MOD;
                end
                ST_MOD: begin
                    state_reg <= ST_MODW;
                end
                ST_MODW: begin
                    if (div_done) begin
                        state_reg <= (div_rem == '0) ? ST_MEANW : ST_IDLE;
                    end
                end
                ST_MEANW: begin
                    if (div_done) begin
                        mean_reg  <= div_quo[RATE_W-1:0];
                        state_reg <= ST_BL1;
                    end
                end
                ST_BL1: begin
                    state_reg <= ST_BL2;
                end
                ST_BL2: begin
                    acc_reg   <= ACC_W'(prod_reg) + ACC_W'(Q16_HALF);
                    state_reg <= ST_BL3;
                end
                ST_BL3: begin
                    rate_reg  <= mix_res;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        blend_out_reg  <= rate_reg;
                        frames_out_reg <= frame_total_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({frames_out_reg, blend_out_reg});

endmodule

`default_nettype wire

// ===== bench/frame_rate_meter_tb.sv =====
// Self-checking testbench for the frame rate meter: timestamp stimulus, rate prediction, checks.
`timescale 1ns / 100ps

module frame_rate_meter_tb;
    import frm_pkg::*;

    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int WINDOW     = WINDOW_DEPTH_DEF;
    localparam int M_W        = ((FRAC_BITS + 43 + 7) / 8) * 8;
    localparam int SETTLE     = 200;
    localparam int HOLD_LEN   = 2000;
    localparam int QUIET_MAX  = 20000;
    localparam int PRINT_MAX  = 40;

    typedef struct packed {
        logic [FRAMES_W-1:0]  frames;
        logic [FRAC_BITS+10:0] fps;
    } fps_report_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TS_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_W-1:0]        m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    frame_rate_meter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state and its copy of the registers.
    logic                  m_en;
    logic [MIN_W-1:0]      m_min;
    logic [WEIGHT_W-1:0]   m_ema;
    logic [WEIGHT_W-1:0]   m_blend;
    logic [PERIOD_W-1:0]   m_period;
    logic [TS_W-1:0]       m_last;
    logic [FRAC_BITS+10:0] m_ring [WINDOW];
    int                    m_slot;
    int                    m_fill;
    logic [63:0]           m_sum;
    logic [63:0]           m_smooth;
    logic                  m_seeded;
    logic [FRAMES_W-1:0]   m_total;

    logic [TS_W-1:0]       stamp_q [$];
    fps_report_t           fps_expected [$];
    logic [TS_W-1:0]       gen_time;

    logic                  s_sent = 1'b0;
    logic                  m_got  = 1'b0;
    int                    send_gap    = 0;
    logic                  send_steady = 1'b0;
    int                    recv_wait   = 0;
    logic                  recv_steady = 1'b0;
    int                    hold_cnt    = 0;
    logic                  hold_done   = 1'b0;
    int                    rx_count    = 0;
    int                    quiet       = 0;
    int                    errors      = 0;

    function automatic logic [63:0] q16_mix(input logic [63:0] a, input logic [63:0] b,
                                            input logic [WEIGHT_W-1:0] w);
        logic [63:0] wa;
        wa = (w > Q16_ONE) ? {47'd0, Q16_ONE} : {47'd0, w};
        return (a * wa + b * ({47'd0, Q16_ONE} - wa) + 64'd32768) >> 16;
    endfunction

    function automatic logic predict_frame(input logic [TS_W-1:0] now, output fps_report_t rep);
        logic [63:0]         dt;
        logic [63:0]         rate;
        logic [63:0]         mean;
        logic [63:0]         mix;
        logic [PERIOD_W-1:0] per;
        logic                fired;
        fired = 1'b0;
        rep   = '0;
        if (!m_en)
            return 1'b0;
        if (m_last != 0) begin
            dt = now - m_last;
            if (dt > {32'd0, m_min}) begin
                rate = (NS_PER_SEC << FRAC_BITS) / dt;
                if (rate != 0 && rate < (RATE_CEIL_FPS << FRAC_BITS)) begin
                    m_sum = m_sum - {37'd0, m_ring[m_slot]} + rate;
                    m_ring[m_slot] = rate[FRAC_BITS+10:0];
                    m_slot = (m_slot + 1) % WINDOW;
                    if (m_fill < WINDOW)
                        m_fill++;
                    if (!m_seeded) begin
                        m_smooth = rate;
                        m_seeded = 1'b1;
                    end else begin
                        m_smooth = q16_mix(rate, m_smooth, m_ema);
                    end
                    m_total++;
                    per = (m_period == 0) ? 8'd1 : m_period;
                    if (m_total % per == 0) begin
                        mean       = m_sum / m_fill;
                        mix        = q16_mix(m_smooth, mean, m_blend);
                        rep.fps    = mix[FRAC_BITS+10:0];
                        rep.frames = m_total;
                        fired      = 1'b1;
                    end
                end
            end
        end
        m_last = now;
        return fired;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        errors++;
        if (errors <= PRINT_MAX)
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    // Sender: holds each transaction until taken, then waits its drawn gap.
    always @(negedge aclk) begin
        if (!s_tvalid || s_sent) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (stamp_q.size() != 0) begin
                s_tdata  <= stamp_q.pop_front();
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_steady <= !send_steady;
                send_gap <= send_steady ? 0 : $urandom_range(0, 8);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls each result by a drawn count once it shows up, plus one long hold-off.
    always @(negedge aclk) begin : rx_ready
        int unsigned pause;
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && rx_count >= 40) begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (m_got) begin
            if ($urandom_range(0, 15) == 0)
                recv_steady <= !recv_steady;
            pause = recv_steady ? 0 : $urandom_range(0, 8);
            recv_wait <= pause;
            m_tready  <= (pause == 0);
        end else if (m_tvalid && recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            m_tready  <= (recv_wait == 1);
        end else if (recv_wait == 0) begin
            m_tready <= 1'b1;
        end
    end

    // Monitor, scoreboard and watchdog.
    always @(posedge aclk) begin : watch
        fps_report_t rep;
        fps_report_t want;
        if (aresetn) begin
            s_sent <= s_tvalid && s_tready;
            m_got  <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                if (predict_frame(s_tdata, rep))
                    fps_expected.push_back(rep);
            end
            if (m_tvalid && m_tready) begin
                rx_count++;
                if (fps_expected.size() == 0) begin
                    flag_mismatch("result with nothing pending", m_tdata, 0);
                end else begin
                    want = fps_expected.pop_front();
                    if (m_tdata[FRAC_BITS+10:0] !== want.fps)
                        flag_mismatch("blended_fps", m_tdata[FRAC_BITS+10:0], want.fps);
                    if (m_tdata[FRAC_BITS+42:FRAC_BITS+11] !== want.frames)
                        flag_mismatch("frames", m_tdata[FRAC_BITS+42:FRAC_BITS+11],
                                      want.frames);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_MAX) begin
                    $display("frame_rate_meter_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    task automatic set_config(input logic en, input logic [MIN_W-1:0] min_ns,
                              input logic [WEIGHT_W-1:0] ema, input logic [WEIGHT_W-1:0] blend,
                              input logic [PERIOD_W-1:0] period);
        m_en     = en;
        m_min    = min_ns;
        m_ema    = ema;
        m_blend  = blend;
        m_period = period;
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_wdata <= {31'd0, en};
        @(negedge aclk);
        cfg_index <= CFG_MIN_INTERVAL;
        cfg_wdata <= min_ns;
        @(negedge aclk);
        cfg_index <= CFG_EMA_WEIGHT;
        cfg_wdata <= {15'd0, ema};
        @(negedge aclk);
        cfg_index <= CFG_BLEND_WEIGHT;
        cfg_wdata <= {15'd0, blend};
        @(negedge aclk);
        cfg_index <= CFG_REPORT_PERIOD;
        cfg_wdata <= {24'd0, period};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_at(input logic [TS_W-1:0] t);
        gen_time = t;
        stamp_q.push_back(t);
    endtask

    task automatic drain_and_settle();
        while (!(stamp_q.size() == 0 && !s_tvalid && fps_expected.size() == 0))
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Mostly plausible frame intervals, with some zero, backward, too short and too long times.
    task automatic run_random(input int count);
        logic [63:0] lo;
        int          kind;
        lo = ((m_min < 500000) ? 64'd500000 : {32'd0, m_min}) + 64'd1;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
                gen_time = gen_time + lo + $urandom_range(0, 40000000);
            else if (kind < 86)
                gen_time = gen_time + lo + {28'd0, 4'($urandom_range(0, 15)), $urandom()};
            else if (kind < 89)
                gen_time = {$urandom(), $urandom()};
            else if (kind < 91)
                gen_time = '0;
            else if (kind < 94)
                gen_time = gen_time - $urandom_range(1, 1000000);
            else if (kind < 97)
                gen_time = gen_time + $urandom_range(0, 500000);
            else
                gen_time = gen_time + 64'd65536000000001 + $urandom();
            stamp_q.push_back(gen_time);
        end
        drain_and_settle();
    endtask

    initial begin
        m_en     = 1'b0;
        m_min    = MIN_INTERVAL_RST;
        m_ema    = EMA_WEIGHT_RST;
        m_blend  = BLEND_WEIGHT_RST;
        m_period = REPORT_PERIOD_RST;
        m_last   = '0;
        for (int i = 0; i < WINDOW; i++)
            m_ring[i] = '0;
        m_slot   = 0;
        m_fill   = 0;
        m_sum    = '0;
        m_smooth = '0;
        m_seeded = 1'b0;
        m_total  = '0;
        gen_time = '0;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Disabled after reset: these events must leave no trace.
        push_at(64'd1000);
        push_at(64'd2000000);
        push_at(64'hFFFF_FFFF_FFFF_FFFF);
        drain_and_settle();

        set_config(1'b1, 32'd0, 17'd5243, 17'd45875, 8'd1);
        push_at(64'd100);
        push_at(gen_time + 64'd500000);
        push_at(gen_time + 64'd500001);
        push_at(gen_time + 64'd16666667);
        push_at(gen_time + 64'd1);
        push_at(64'd0);
        push_at(64'd5000000);
        push_at(gen_time + 64'd33333333);
        push_at(64'd4000000);
        push_at(gen_time + 64'd65536000000000);
        push_at(gen_time + 64'd65536000000001);
        push_at(gen_time + 64'd1000000000);
        push_at(64'hFFFF_FFFF_FFFF_0000);
        push_at(gen_time + 64'd16666667);
        push_at(64'hFFFF_FFFF_FFFF_FFFF);
        push_at(gen_time + 64'd8333333);
        drain_and_settle();

        // Weights above one saturate, and a zero period reports every frame.
        set_config(1'b1, 32'd1000000, 17'h1FFFF, 17'h1FFFF, 8'd0);
        push_at(gen_time + 64'd20000000);
        push_at(gen_time + 64'd900000);
        push_at(gen_time + 64'd1000000);
        push_at(gen_time + 64'd1000001);
        push_at(gen_time + 64'd12000000);
        drain_and_settle();

        set_config(1'b1, 32'd500000, 17'd5243, 17'd45875, 8'd8);
        run_random(220);
        set_config(1'b1, 32'd0, 17'd65536, 17'd0, 8'd1);
        run_random(220);
        set_config(1'b1, 32'hFFFF_FFFF, 17'd0, 17'd65536, 8'd255);
        run_random(200);
        set_config(1'b0, 32'd500000, 17'd5243, 17'd45875, 8'd8);
        run_random(40);
        set_config(1'b1, 32'd2000000, 17'h1FFFF, 17'h1FFFF, 8'd0);
        run_random(220);
        set_config(1'b1, 32'd0, 17'd0, 17'd0, 8'd3);
        run_random(200);
        repeat (4) begin
            set_config(1'b1, $urandom_range(0, 20000000), $urandom_range(0, 131071),
                       $urandom_range(0, 131071), $urandom_range(0, 16));
            run_random(200);
        end

        if (fps_expected.size() != 0)
            flag_mismatch("results never delivered", 0, fps_expected.size());
        if (errors == 0)
            $display("frame_rate_meter_tb: done, clean");
        else
            $display("frame_rate_meter_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/frm_pkg.sv
rtl/core/frm_div.sv
rtl/core/frame_rate_meter.sv
bench/frame_rate_meter_tb.sv
